[design/lfu_cached_reference_table_defines.svh]
// Assertion macros shared by the design files.
`ifndef LFU_CACHED_REFERENCE_TABLE_DEFINES_SVH
`define LFU_CACHED_REFERENCE_TABLE_DEFINES_SVH

// Same-cycle implication.
`define LFU_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("lfu: check failed");

// Next-cycle implication.
`define LFU_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("lfu: check failed");

`endif

[design/lfu_pkg.sv]
package lfu_pkg;

   localparam int CACHE_ENTRIES = 8;
   localparam int TABLE_DEPTH   = 256;

   localparam int KEY_W    = 32;
   localparam int USES_W   = 16;
   localparam int SLOT_W   = 8;
   localparam int STATUS_W = 2;
   localparam int ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int CIDX_W   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

   localparam logic [USES_W-1:0] USES_MAX = '1;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_ADD    = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic                load;
      logic                cache_update;
      logic                scan_start;
      logic                scan_run;
      logic                append;
      logic                install;
      logic                set_status;
      logic [STATUS_W-1:0] status;
   } lfu_cmd_type;

   typedef struct packed {
      logic kind;
      logic cache_hit;
      logic scan_match;
      logic scan_done;
      logic table_full;
   } lfu_sts_type;

endpackage

[design/lfu_cached_reference_table.sv]
// A cache hit responds without scanning the table; a table hit or an appended key is then
// installed in the cache before the response, while a lookup miss or a full table responds
// straight after the scan.
// Throughput: one word at a time, the next taken the cycle after the strobe; the table scan
// reads one key per cycle from a memory with one write port and one read port.
// The receiver cannot stall. Synchronous reset empties the cache and the table at once.
module lfu_cached_reference_table (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_kind,
   input  logic signed [lfu_pkg::KEY_W-1:0] req_reference,
   output logic                             rsp_valid,
   output logic [lfu_pkg::STATUS_W-1:0]     rsp_status,
   output logic [lfu_pkg::SLOT_W-1:0]       rsp_slot_index,
   output logic                             rsp_cache_hit
);
   import lfu_pkg::*;

   lfu_cmd_type cmd;
   lfu_sts_type sts;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   lfu_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_kind       (req_kind),
      .req_reference  (req_reference),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .rsp_cache_hit  (rsp_cache_hit)
   );

endmodule

[design/lfu_ctrl.sv]
`include "lfu_cached_reference_table_defines.svh"

module lfu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  lfu_pkg::lfu_sts_type sts,
   output lfu_pkg::lfu_cmd_type cmd
);
   import lfu_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_LOOKUP  = 5'b00010,
      S_SCAN    = 5'b00100,
      S_INSTALL = 5'b01000,
      S_RESPOND = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (sts.cache_hit) begin
               cmd.cache_update = 1'b1;
               cmd.set_status   = 1'b1;
               cmd.status       = (sts.kind == KIND_ADD) ? ST_DUPLICATE : ST_OK;
               state_in         = S_RESPOND;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_match) begin
               cmd.set_status = 1'b1;
               cmd.status     = (sts.kind == KIND_ADD) ? ST_DUPLICATE : ST_OK;
               state_in       = S_INSTALL;
            end else if (sts.scan_done) begin
               cmd.set_status = 1'b1;
               if (sts.kind == KIND_LOOKUP) begin
                  cmd.status = ST_NOT_FOUND;
                  state_in   = S_RESPOND;
               end else if (sts.table_full) begin
                  cmd.status = ST_FULL;
                  state_in   = S_RESPOND;
               end else begin
                  cmd.append = 1'b1;
                  cmd.status = ST_OK;
                  state_in   = S_INSTALL;
               end
            end
         end
         S_INSTALL: begin
            cmd.install = 1'b1;
            state_in    = S_RESPOND;
         end
         S_RESPOND: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESPOND);

   `LFU_ASSERT_NEXT(a_resp_then_idle, clock, reset, rsp_valid, !busy && !rsp_valid)
   `LFU_ASSERT_NOW(a_append_only_on_add, clock, reset, cmd.append, sts.kind && !sts.table_full)

endmodule

[design/lfu_dpath.sv]
`include "lfu_cached_reference_table_defines.svh"

module lfu_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  lfu_pkg::lfu_cmd_type           cmd,
   output lfu_pkg::lfu_sts_type           sts,
   input  logic                           req_kind,
   input  logic signed [lfu_pkg::KEY_W-1:0] req_reference,
   output logic [lfu_pkg::STATUS_W-1:0]   rsp_status,
   output logic [lfu_pkg::SLOT_W-1:0]     rsp_slot_index,
   output logic                           rsp_cache_hit
);
   import lfu_pkg::*;

   logic                kind_ff;
   logic [KEY_W-1:0]    key_ff;

   logic [CACHE_ENTRIES-1:0] cvalid_ff;
   logic [KEY_W-1:0]    ckey_ff  [CACHE_ENTRIES];
   logic [ADDR_W-1:0]   cslot_ff [CACHE_ENTRIES];
   logic [USES_W-1:0]   cuses_ff [CACHE_ENTRIES];

   logic [KEY_W-1:0]    key_mem [TABLE_DEPTH];

   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic [COUNT_W-1:0]  scan_addr_ff;
   logic [COUNT_W-1:0]  scan_addr_in;
   logic                rd_vld_ff;
   logic                rd_vld_in;
   logic [ADDR_W-1:0]   rd_addr_ff;
   logic [KEY_W-1:0]    rd_data_ff;

   logic [ADDR_W-1:0]   pos_ff;
   logic [ADDR_W-1:0]   pos_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic                hit_ff;
   logic                hit_in;

   logic [CACHE_ENTRIES-1:0] hit_vec;
   logic                hit_any;
   logic [CIDX_W-1:0]   hit_idx;
   logic [CIDX_W-1:0]   victim;
   logic [USES_W-1:0]   low_uses;
   logic                issue;
   logic                scan_match;
   logic                table_full;

   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
         hit_vec[i] = cvalid_ff[i] && (ckey_ff[i] == key_ff);
         if (hit_vec[i]) begin
            hit_any = 1'b1;
            hit_idx = CIDX_W'(i);
         end
      end
   end

   // lowest count wins, lowest index on ties
   always_comb begin
      victim   = '0;
      low_uses = cuses_ff[0];
      for (int i = 1; i < CACHE_ENTRIES; i++) begin
         if (cuses_ff[i] < low_uses) begin
            low_uses = cuses_ff[i];
            victim   = CIDX_W'(i);
         end
      end
   end

   assign issue      = cmd.scan_run && (scan_addr_ff < count_ff);
   assign scan_match = rd_vld_ff && (rd_data_ff == key_ff);
   assign table_full = (count_ff == COUNT_W'(TABLE_DEPTH));

   always_comb begin
      scan_addr_in = scan_addr_ff;
      if (cmd.scan_start) begin
         scan_addr_in = '0;
      end else if (issue) begin
         scan_addr_in = scan_addr_ff + 1'b1;
      end
      rd_vld_in = issue;
      count_in  = cmd.append ? count_ff + 1'b1 : count_ff;

      pos_in = pos_ff;
      if (cmd.load) begin
         pos_in = '0;
      end else if (cmd.cache_update) begin
         pos_in = cslot_ff[hit_idx];
      end else if (cmd.scan_run && scan_match) begin
         pos_in = rd_addr_ff;
      end else if (cmd.append) begin
         pos_in = count_ff[ADDR_W-1:0];
      end

      hit_in = hit_ff;
      if (cmd.load) begin
         hit_in = 1'b0;
      end else if (cmd.cache_update) begin
         hit_in = 1'b1;
      end

      status_in = cmd.set_status ? cmd.status : status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cvalid_ff <= '0;
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            cuses_ff[i] <= '0;
         end
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
         if (cmd.cache_update && (cuses_ff[hit_idx] != USES_MAX)) begin
            cuses_ff[hit_idx] <= cuses_ff[hit_idx] + 1'b1;
         end
         if (cmd.install) begin
            cvalid_ff[victim] <= 1'b1;
            cuses_ff[victim]  <= USES_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         key_ff  <= $unsigned(req_reference);
      end
      if (cmd.install) begin
         ckey_ff[victim]  <= key_ff;
         cslot_ff[victim] <= pos_ff;
      end
      scan_addr_ff <= scan_addr_in;
      pos_ff       <= pos_in;
      hit_ff       <= hit_in;
      status_ff    <= status_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         key_mem[count_ff[ADDR_W-1:0]] <= key_ff;
      end
      rd_data_ff <= key_mem[scan_addr_ff[ADDR_W-1:0]];
      rd_addr_ff <= scan_addr_ff[ADDR_W-1:0];
   end

   assign sts.kind       = kind_ff;
   assign sts.cache_hit  = hit_any;
   assign sts.scan_match = scan_match;
   assign sts.scan_done  = !issue && !rd_vld_ff;
   assign sts.table_full = table_full;

   assign rsp_status     = status_ff;
   assign rsp_slot_index = SLOT_W'(pos_ff);
   assign rsp_cache_hit  = hit_ff;

   `LFU_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_W'(TABLE_DEPTH))
   `LFU_ASSERT_NOW(a_cache_keys_unique, clock, reset, 1'b1, $onehot0(hit_vec))
   `LFU_ASSERT_NEXT(a_install_sets_valid, clock, reset, cmd.install, cvalid_ff != '0)

endmodule
